@@ hw/rtl/sphere_vertex_generator_core_defines.svh @@
// Assertion macros used by the sphere vertex generator checker.
`ifndef SPHERE_VERTEX_GENERATOR_CORE_DEFINES_SVH
`define SPHERE_VERTEX_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define SVG_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sphere vertex generator: check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define SVG_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sphere vertex generator: check failed");

`endif

@@ hw/rtl/svg_pkg.sv @@
// Types, constants and tables shared by the sphere vertex generator modules.
package svg_pkg;

	localparam int COUNT_W      = 11;
	localparam int RADIUS_W     = 16;
	localparam int POS_W        = 17;
	localparam int UNIT_W       = 16;
	localparam int TEX_W        = 17;
	localparam int ANGLE_W      = 32;
	localparam int QUO_W        = ANGLE_W + 1;
	localparam int DIV_LAT      = QUO_W;
	localparam int CORDIC_STEPS = 18;
	localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;

	localparam int CORDIC_GAIN_INIT = 652032874;
	localparam int ONE_Q14          = 16384;
	localparam int TAN_LIMIT        = 16367;

	localparam int SLICE_COUNT_RESET = 16;
	localparam int RING_COUNT_RESET  = 16;
	localparam int RADIUS_RESET      = 256;

	localparam logic [CFG_IDX_W-1:0] REG_SLICE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RING_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 2'd2;

	typedef struct packed {
		logic [COUNT_W-1:0] ring;
		logic [COUNT_W-1:0] slice;
		logic [COUNT_W-1:0] ring_n;
		logic [COUNT_W-1:0] slice_n;
		logic               pole;
	} svg_item_t;

	function automatic logic [ANGLE_W-1:0] atan_step(input int unsigned i);
		case (i)
			0:  return 32'd536870912;
			1:  return 32'd316933406;
			2:  return 32'd167458907;
			3:  return 32'd85004757;
			4:  return 32'd42667331;
			5:  return 32'd21354465;
			6:  return 32'd10679838;
			7:  return 32'd5340245;
			8:  return 32'd2670163;
			9:  return 32'd1335087;
			10: return 32'd667544;
			11: return 32'd333772;
			12: return 32'd166886;
			13: return 32'd83443;
			14: return 32'd41722;
			15: return 32'd20861;
			16: return 32'd10430;
			17: return 32'd5215;
			default: return '0;
		endcase
	endfunction

endpackage

@@ hw/rtl/svg_front.sv @@
// Front end: accepts index transactions, clamps them and queues them for the datapath.
module svg_front #(
	parameter int MAX_SEGMENTS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [svg_pkg::COUNT_W-1:0] slice_count,
	input  logic [svg_pkg::COUNT_W-1:0] ring_count,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic [svg_pkg::COUNT_W-1:0] ring_index,
	input  logic [svg_pkg::COUNT_W-1:0] slice_index,
	input  logic                        pop,
	output logic                        head_valid,
	output svg_pkg::svg_item_t          head
);
	import svg_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] n);
		if (n == '0) begin
			return COUNT_W'(1);
		end else if (int'(n) > MAX_SEGMENTS) begin
			return COUNT_W'(MAX_SEGMENTS);
		end
		return n;
	endfunction

	logic [COUNT_W-1:0] rings;
	logic [COUNT_W-1:0] slices;
	svg_item_t          item;
	logic               push;

	svg_item_t          mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	always_comb begin
		rings        = eff_count(ring_count);
		slices       = eff_count(slice_count);
		item.ring_n  = rings;
		item.slice_n = slices;
		item.ring    = (ring_index > rings) ? rings : ring_index;
		item.slice   = (slice_index > slices) ? slices : slice_index;
		item.pole    = (item.ring == '0);
	end

	assign item_stall = (count_q == CNT_W'(DEPTH));
	assign push       = item_valid && !item_stall;
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/svg_div.sv @@
// Pipelined restoring divider giving floor(num * 2^32 / den) for num <= den.
module svg_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [svg_pkg::COUNT_W-1:0] num,
	input  logic [svg_pkg::COUNT_W-1:0] den,
	output logic [svg_pkg::QUO_W-1:0]   quo
);
	import svg_pkg::*;

	localparam int REM_W = COUNT_W + 1;

	logic [REM_W-1:0]   rem_q [DIV_LAT];
	logic [QUO_W-1:0]   quo_q [DIV_LAT];
	logic [COUNT_W-1:0] den_q [DIV_LAT];

	logic [REM_W-1:0]   dbl   [DIV_LAT];
	logic               ge    [DIV_LAT];
	logic [REM_W-1:0]   nrem  [DIV_LAT];
	logic [QUO_W-1:0]   nquo  [DIV_LAT];
	logic               whole;

	always_comb begin
		whole   = (num >= den);
		nrem[0] = whole ? '0 : {1'b0, num};
		nquo[0] = {{(QUO_W-1){1'b0}}, whole};
		dbl[0]  = '0;
		ge[0]   = 1'b0;
		for (int k = 1; k < DIV_LAT; k++) begin
			dbl[k]  = {rem_q[k-1][REM_W-2:0], 1'b0};
			ge[k]   = (dbl[k] >= {1'b0, den_q[k-1]});
			nrem[k] = ge[k] ? (dbl[k] - {1'b0, den_q[k-1]}) : dbl[k];
			nquo[k] = {quo_q[k-1][QUO_W-2:0], ge[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_q[0] <= den;
			for (int k = 0; k < DIV_LAT; k++) begin
				rem_q[k] <= nrem[k];
				quo_q[k] <= nquo[k];
			end
			for (int k = 1; k < DIV_LAT; k++) begin
				den_q[k] <= den_q[k-1];
			end
		end
	end

	assign quo = quo_q[DIV_LAT-1];

endmodule

@@ hw/rtl/svg_cordic.sv @@
// Pipelined rotation CORDIC giving Q1.14 sine and cosine of a binary angle.
module svg_cordic (
	input  logic                               clk,
	input  logic                               en,
	input  logic [svg_pkg::ANGLE_W-1:0]        angle,
	output logic signed [svg_pkg::UNIT_W-1:0]  sine,
	output logic signed [svg_pkg::UNIT_W-1:0]  cosine
);
	import svg_pkg::*;

	localparam int XY_W = ANGLE_W + 1;
	localparam int Z_W  = ANGLE_W + 2;

	function automatic logic signed [UNIT_W-1:0] unit_round(input logic signed [XY_W-1:0] v);
		logic [XY_W-1:0] mag;
		logic [XY_W-1:0] r;
		mag = v[XY_W-1] ? XY_W'(-v) : XY_W'(v);
		r   = (mag + XY_W'(32768)) >> 16;
		if (r > XY_W'(ONE_Q14)) begin
			r = XY_W'(ONE_Q14);
		end
		return v[XY_W-1] ? -$signed(UNIT_W'(r)) : $signed(UNIT_W'(r));
	endfunction

	logic signed [XY_W-1:0] x_q [CORDIC_STEPS+1];
	logic signed [XY_W-1:0] y_q [CORDIC_STEPS+1];
	logic signed [Z_W-1:0]  z_q [CORDIC_STEPS+1];
	logic                   neg_q [CORDIC_STEPS+1];
	logic signed [UNIT_W-1:0] sine_q;
	logic signed [UNIT_W-1:0] cosine_q;

	logic signed [XY_W-1:0] nx [CORDIC_STEPS+1];
	logic signed [XY_W-1:0] ny [CORDIC_STEPS+1];
	logic signed [Z_W-1:0]  nz [CORDIC_STEPS+1];
	logic signed [Z_W-1:0]  atan_z [CORDIC_STEPS+1];
	logic                   fold;
	logic [ANGLE_W-1:0]     folded;
	logic signed [XY_W-1:0] xf;
	logic signed [XY_W-1:0] yf;

	always_comb begin
		fold      = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];
		folded    = {angle[ANGLE_W-1] ^ fold, angle[ANGLE_W-2:0]};
		nx[0]     = XY_W'(CORDIC_GAIN_INIT);
		ny[0]     = '0;
		nz[0]     = $signed({{(Z_W-ANGLE_W){folded[ANGLE_W-1]}}, folded});
		atan_z[0] = '0;
		for (int k = 1; k <= CORDIC_STEPS; k++) begin
			atan_z[k] = $signed({{(Z_W-ANGLE_W){1'b0}}, atan_step(k - 1)});
			if (!z_q[k-1][Z_W-1]) begin
				nx[k] = x_q[k-1] - (y_q[k-1] >>> (k - 1));
				ny[k] = y_q[k-1] + (x_q[k-1] >>> (k - 1));
				nz[k] = z_q[k-1] - atan_z[k];
			end else begin
				nx[k] = x_q[k-1] + (y_q[k-1] >>> (k - 1));
				ny[k] = y_q[k-1] - (x_q[k-1] >>> (k - 1));
				nz[k] = z_q[k-1] + atan_z[k];
			end
		end
		xf = neg_q[CORDIC_STEPS] ? -x_q[CORDIC_STEPS] : x_q[CORDIC_STEPS];
		yf = neg_q[CORDIC_STEPS] ? -y_q[CORDIC_STEPS] : y_q[CORDIC_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_q[0] <= fold;
			for (int k = 0; k <= CORDIC_STEPS; k++) begin
				x_q[k] <= nx[k];
				y_q[k] <= ny[k];
				z_q[k] <= nz[k];
			end
			for (int k = 1; k <= CORDIC_STEPS; k++) begin
				neg_q[k] <= neg_q[k-1];
			end
			cosine_q <= unit_round(xf);
			sine_q   <= unit_round(yf);
		end
	end

	assign sine   = sine_q;
	assign cosine = cosine_q;

endmodule

@@ hw/rtl/svg_back.sv @@
// Back end: dividers, CORDICs and vertex arithmetic with the output register.
module svg_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               head_valid,
	input  svg_pkg::svg_item_t                 head,
	output logic                               pop,
	input  logic [svg_pkg::RADIUS_W-1:0]       radius,
	output logic                               vertex_valid,
	input  logic                               vertex_stall,
	output logic signed [svg_pkg::POS_W-1:0]   pos_x,
	output logic signed [svg_pkg::POS_W-1:0]   pos_y,
	output logic signed [svg_pkg::POS_W-1:0]   pos_z,
	output logic signed [svg_pkg::UNIT_W-1:0]  normal_x,
	output logic signed [svg_pkg::UNIT_W-1:0]  normal_y,
	output logic signed [svg_pkg::UNIT_W-1:0]  normal_z,
	output logic signed [svg_pkg::UNIT_W-1:0]  tangent_x,
	output logic signed [svg_pkg::UNIT_W-1:0]  tangent_y,
	output logic signed [svg_pkg::UNIT_W-1:0]  tangent_z,
	output logic [svg_pkg::TEX_W-1:0]          tex_u,
	output logic [svg_pkg::TEX_W-1:0]          tex_v
);
	import svg_pkg::*;

	localparam int SXP_W   = 2 * UNIT_W;
	localparam int RAD_S_W = RADIUS_W + 1;
	localparam int YCP_W   = RAD_S_W + UNIT_W;
	localparam int PROD_W  = RAD_S_W + SXP_W;
	localparam int FRONT_LAT = DIV_LAT + CORDIC_LAT;
	localparam int VLD_LEN   = FRONT_LAT + 2;
	localparam logic signed [UNIT_W-1:0] TAN_MAX  = UNIT_W'(TAN_LIMIT);
	localparam logic signed [UNIT_W-1:0] UNIT_ONE = UNIT_W'(ONE_Q14);

	function automatic logic signed [PROD_W-1:0] round_shift(
		input logic signed [PROD_W-1:0] v,
		input int n
	);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] r;
		mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
		r   = (mag + (PROD_W'(1) << (n - 1))) >> n;
		return v[PROD_W-1] ? -$signed(r) : $signed(r);
	endfunction

	logic                      adv;
	logic [QUO_W-1:0]          quo_ring;
	logic [QUO_W-1:0]          quo_slice;
	logic signed [UNIT_W-1:0]  sp;
	logic signed [UNIT_W-1:0]  cp;
	logic signed [UNIT_W-1:0]  sa;
	logic signed [UNIT_W-1:0]  ca;
	logic signed [RAD_S_W-1:0] rad_s;

	logic                      vld_q    [VLD_LEN];
	logic                      pole_q   [FRONT_LAT];
	logic [TEX_W-1:0]          texu_q   [CORDIC_LAT];
	logic [TEX_W-1:0]          texv_q   [CORDIC_LAT];

	logic signed [SXP_W-1:0]   sxp_s1;
	logic signed [SXP_W-1:0]   cxp_s1;
	logic signed [YCP_W-1:0]   ycp_s1;
	logic signed [UNIT_W-1:0]  sa_s1;
	logic signed [UNIT_W-1:0]  ca_s1;
	logic signed [UNIT_W-1:0]  cp_s1;
	logic                      pole_s1;
	logic [TEX_W-1:0]          texu_s1;
	logic [TEX_W-1:0]          texv_s1;

	logic signed [PROD_W-1:0]  pxp_s2;
	logic signed [PROD_W-1:0]  pzp_s2;
	logic signed [POS_W-1:0]   posy_s2;
	logic signed [UNIT_W-1:0]  nx_s2;
	logic signed [UNIT_W-1:0]  ny_s2;
	logic signed [UNIT_W-1:0]  nz_s2;
	logic signed [UNIT_W-1:0]  tx_s2;
	logic signed [UNIT_W-1:0]  tz_s2;
	logic [TEX_W-1:0]          texu_s2;
	logic [TEX_W-1:0]          texv_s2;

	logic                      out_valid_q;
	logic signed [POS_W-1:0]   pos_x_q;
	logic signed [POS_W-1:0]   pos_y_q;
	logic signed [POS_W-1:0]   pos_z_q;
	logic signed [UNIT_W-1:0]  normal_x_q;
	logic signed [UNIT_W-1:0]  normal_y_q;
	logic signed [UNIT_W-1:0]  normal_z_q;
	logic signed [UNIT_W-1:0]  tangent_x_q;
	logic signed [UNIT_W-1:0]  tangent_z_q;
	logic [TEX_W-1:0]          tex_u_q;
	logic [TEX_W-1:0]          tex_v_q;

	logic signed [UNIT_W-1:0]  ny_c;
	logic                      flat_c;

	assign adv   = !out_valid_q || !vertex_stall;
	assign pop   = adv && head_valid;
	assign rad_s = $signed({1'b0, radius});

	svg_div u_div_ring (
		.clk (clk),
		.en  (adv),
		.num (head.ring),
		.den (head.ring_n),
		.quo (quo_ring)
	);

	svg_div u_div_slice (
		.clk (clk),
		.en  (adv),
		.num (head.slice),
		.den (head.slice_n),
		.quo (quo_slice)
	);

	svg_cordic u_cordic_pol (
		.clk    (clk),
		.en     (adv),
		.angle  (quo_ring[QUO_W-1:1]),
		.sine   (sp),
		.cosine (cp)
	);

	svg_cordic u_cordic_az (
		.clk    (clk),
		.en     (adv),
		.angle  (quo_slice[ANGLE_W-1:0]),
		.sine   (sa),
		.cosine (ca)
	);

	always_comb begin
		ny_c   = pole_s1 ? UNIT_ONE : cp_s1;
		flat_c = (ny_c <= TAN_MAX) && (ny_c >= -TAN_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < VLD_LEN; k++) begin
				vld_q[k] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= pop;
			for (int k = 1; k < VLD_LEN; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
			out_valid_q <= vld_q[VLD_LEN-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pole_q[0] <= head.pole;
			for (int k = 1; k < FRONT_LAT; k++) begin
				pole_q[k] <= pole_q[k-1];
			end
			texu_q[0] <= quo_slice[QUO_W-1:QUO_W-TEX_W];
			texv_q[0] <= quo_ring[QUO_W-1:QUO_W-TEX_W];
			for (int k = 1; k < CORDIC_LAT; k++) begin
				texu_q[k] <= texu_q[k-1];
				texv_q[k] <= texv_q[k-1];
			end

			sxp_s1  <= SXP_W'(sa) * SXP_W'(sp);
			cxp_s1  <= SXP_W'(ca) * SXP_W'(sp);
			ycp_s1  <= YCP_W'(rad_s) * YCP_W'(cp);
			sa_s1   <= sa;
			ca_s1   <= ca;
			cp_s1   <= cp;
			pole_s1 <= pole_q[FRONT_LAT-1];
			texu_s1 <= texu_q[CORDIC_LAT-1];
			texv_s1 <= texv_q[CORDIC_LAT-1];

			pxp_s2  <= PROD_W'(rad_s) * PROD_W'(sxp_s1);
			pzp_s2  <= PROD_W'(rad_s) * PROD_W'(cxp_s1);
			posy_s2 <= POS_W'(round_shift(PROD_W'(ycp_s1), 14));
			nx_s2   <= pole_s1 ? '0 : UNIT_W'(round_shift(PROD_W'(sxp_s1), 14));
			nz_s2   <= pole_s1 ? '0 : UNIT_W'(round_shift(PROD_W'(cxp_s1), 14));
			ny_s2   <= ny_c;
			tx_s2   <= flat_c ? -ca_s1 : UNIT_ONE;
			tz_s2   <= flat_c ? sa_s1 : '0;
			texu_s2 <= texu_s1;
			texv_s2 <= texv_s1;

			pos_x_q     <= POS_W'(round_shift(pxp_s2, 28));
			pos_y_q     <= posy_s2;
			pos_z_q     <= POS_W'(round_shift(pzp_s2, 28));
			normal_x_q  <= nx_s2;
			normal_y_q  <= ny_s2;
			normal_z_q  <= nz_s2;
			tangent_x_q <= tx_s2;
			tangent_z_q <= tz_s2;
			tex_u_q     <= texu_s2;
			tex_v_q     <= texv_s2;
		end
	end

	assign vertex_valid = out_valid_q;
	assign pos_x        = pos_x_q;
	assign pos_y        = pos_y_q;
	assign pos_z        = pos_z_q;
	assign normal_x     = normal_x_q;
	assign normal_y     = normal_y_q;
	assign normal_z     = normal_z_q;
	assign tangent_x    = tangent_x_q;
	assign tangent_y    = '0;
	assign tangent_z    = tangent_z_q;
	assign tex_u        = tex_u_q;
	assign tex_v        = tex_v_q;

endmodule

@@ hw/rtl/sphere_vertex_generator_core.sv @@
// Top level of the UV sphere vertex generator: configuration registers, front end and back end.
// Usage:
// Each input transaction on the item channel carries a ring and a slice index and yields
// exactly one vertex transaction: position (Q8.8), unit normal and tangent (Q1.14) and
// texture coordinates (Q1.16). Indices above the configured counts are clamped.
// The front end clamps indices and places them in a four-entry queue. The back end runs
// two 33-stage dividers, two 20-stage CORDIC pipelines and two multiply stages.
// Throughput is one vertex per cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its transaction and the back end
// freezes; the queue keeps accepting until it holds four items, then item_stall rises.
// Configuration writes take effect at once and belong in idle periods.
// Reset empties the queue and the pipeline and loads the counts with 16 and the
// radius with 1.0.
module sphere_vertex_generator_core #(
	parameter int MAX_SEGMENTS = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [svg_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [svg_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic [svg_pkg::COUNT_W-1:0]          ring_index,
	input  logic [svg_pkg::COUNT_W-1:0]          slice_index,
	output logic                                 vertex_valid,
	input  logic                                 vertex_stall,
	output logic signed [svg_pkg::POS_W-1:0]     pos_x,
	output logic signed [svg_pkg::POS_W-1:0]     pos_y,
	output logic signed [svg_pkg::POS_W-1:0]     pos_z,
	output logic signed [svg_pkg::UNIT_W-1:0]    normal_x,
	output logic signed [svg_pkg::UNIT_W-1:0]    normal_y,
	output logic signed [svg_pkg::UNIT_W-1:0]    normal_z,
	output logic signed [svg_pkg::UNIT_W-1:0]    tangent_x,
	output logic signed [svg_pkg::UNIT_W-1:0]    tangent_y,
	output logic signed [svg_pkg::UNIT_W-1:0]    tangent_z,
	output logic [svg_pkg::TEX_W-1:0]            tex_u,
	output logic [svg_pkg::TEX_W-1:0]            tex_v
);
	import svg_pkg::*;

	logic [COUNT_W-1:0]  slice_count_q;
	logic [COUNT_W-1:0]  ring_count_q;
	logic [RADIUS_W-1:0] radius_q;
	logic                head_valid;
	svg_item_t           head;
	logic                pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_count_q <= COUNT_W'(SLICE_COUNT_RESET);
			ring_count_q  <= COUNT_W'(RING_COUNT_RESET);
			radius_q      <= RADIUS_W'(RADIUS_RESET);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SLICE_COUNT: slice_count_q <= cfg_data[COUNT_W-1:0];
				REG_RING_COUNT:  ring_count_q  <= cfg_data[COUNT_W-1:0];
				REG_RADIUS:      radius_q      <= cfg_data[RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	svg_front #(
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.slice_count (slice_count_q),
		.ring_count  (ring_count_q),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.ring_index  (ring_index),
		.slice_index (slice_index),
		.pop         (pop),
		.head_valid  (head_valid),
		.head        (head)
	);

	svg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.radius       (radius_q),
		.vertex_valid (vertex_valid),
		.vertex_stall (vertex_stall),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.normal_z     (normal_z),
		.tangent_x    (tangent_x),
		.tangent_y    (tangent_y),
		.tangent_z    (tangent_z),
		.tex_u        (tex_u),
		.tex_v        (tex_v)
	);

endmodule

@@ hw/rtl/svg_checker.sv @@
// Port-level checker for the sphere vertex generator and its bind to the top level.
`include "sphere_vertex_generator_core_defines.svh"

module svg_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 cfg_write,
	input logic [svg_pkg::CFG_IDX_W-1:0]        cfg_index,
	input logic [svg_pkg::CFG_DATA_W-1:0]       cfg_data,
	input logic                                 item_valid,
	input logic                                 item_stall,
	input logic [svg_pkg::COUNT_W-1:0]          ring_index,
	input logic [svg_pkg::COUNT_W-1:0]          slice_index,
	input logic                                 vertex_valid,
	input logic                                 vertex_stall,
	input logic signed [svg_pkg::POS_W-1:0]     pos_x,
	input logic signed [svg_pkg::POS_W-1:0]     pos_y,
	input logic signed [svg_pkg::POS_W-1:0]     pos_z,
	input logic signed [svg_pkg::UNIT_W-1:0]    normal_x,
	input logic signed [svg_pkg::UNIT_W-1:0]    normal_y,
	input logic signed [svg_pkg::UNIT_W-1:0]    normal_z,
	input logic signed [svg_pkg::UNIT_W-1:0]    tangent_x,
	input logic signed [svg_pkg::UNIT_W-1:0]    tangent_y,
	input logic signed [svg_pkg::UNIT_W-1:0]    tangent_z,
	input logic [svg_pkg::TEX_W-1:0]            tex_u,
	input logic [svg_pkg::TEX_W-1:0]            tex_v
);

	`SVG_ASSERT_NEXT(a_out_hold, vertex_valid && vertex_stall, vertex_valid && $stable(pos_x) && $stable(normal_y) && $stable(tex_u))
	`SVG_ASSERT_IMP(a_tangent_y_zero, vertex_valid, tangent_y == 16'sd0)
	`SVG_ASSERT_IMP(a_tex_range, vertex_valid, tex_u <= 17'd65536 && tex_v <= 17'd65536)
	`SVG_ASSERT_IMP(a_pole_normal, vertex_valid && tex_v == 17'd0, normal_x == 16'sd0 && normal_z == 16'sd0 && normal_y == 16'sd16384)
	`SVG_ASSERT_IMP(a_pole_tangent, vertex_valid && tex_v == 17'd0, tangent_x == 16'sd16384 && tangent_z == 16'sd0)

endmodule

bind sphere_vertex_generator_core svg_checker u_svg_checker (.*);
